### hw/rtl/srv_pkg.sv
`timescale 1ns / 1ps
package srv_pkg;

    // sample and coefficient formats
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 15;
    localparam int MCOEF_W  = COEF_W + 1;
    localparam int DIGIT_W  = 4;
    localparam int MUL_STEPS = MCOEF_W / DIGIT_W;
    localparam int MSTEP_W  = $clog2(MUL_STEPS);
    localparam int PROD_W   = SAMPLE_W + MCOEF_W + 1;
    localparam int ACC_W    = PROD_W + 1;

    // filter bank geometry
    localparam int COMB_COUNT        = 6;
    localparam int ALLPASS_COUNT     = 2;
    localparam int COMB_DEPTH_MAX    = 4096;
    localparam int ALLPASS_DEPTH_MAX = 256;
    localparam int CK_W    = $clog2(COMB_COUNT);
    localparam int AK_W    = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
    localparam int CPOS_W  = $clog2(COMB_DEPTH_MAX);
    localparam int APOS_W  = $clog2(ALLPASS_DEPTH_MAX);
    localparam int CADDR_W = CK_W + CPOS_W;
    localparam int AADDR_W = AK_W + APOS_W;
    localparam int CSUM_W  = SAMPLE_W + CK_W + 1;
    localparam int DIV_W   = CSUM_W;
    localparam int DCNT_W  = $clog2(DIV_W);

    // filter lengths in samples at 48 kHz, already within the per-filter depth
    localparam logic [CPOS_W:0] COMB_LEN [COMB_COUNT] = '{
        13'd1492, 13'd1867, 13'd2068, 13'd2212, 13'd2510, 13'd2942
    };
    localparam logic [APOS_W:0] AP_LEN [ALLPASS_COUNT] = '{9'd240, 9'd81};

    // register map
    localparam logic [1:0] REG_DECAY   = 2'd0;
    localparam logic [1:0] REG_DAMPING = 2'd1;
    localparam logic [1:0] REG_WET     = 2'd2;
    localparam logic [1:0] REG_APGAIN  = 2'd3;

    localparam logic [COEF_W-1:0] DECAY_RST   = 15'd28508;
    localparam logic [COEF_W-1:0] DAMPING_RST = 15'd14746;
    localparam logic [COEF_W-1:0] WET_RST     = 15'd20316;
    localparam logic [COEF_W-1:0] APGAIN_RST  = 15'd16384;

    localparam logic [MCOEF_W-1:0] Q_ONE = MCOEF_W'(1 << COEF_W);
    localparam logic signed [ACC_W-1:0] Q_ROUND = ACC_W'(1 << (COEF_W - 1));

    // multiplier request and response
    typedef struct packed {
        logic                       start;
        logic signed [SAMPLE_W-1:0] a;
        logic [MCOEF_W-1:0]         coef;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

    // round a Q.15 product to nearest, halves upwards
    function automatic logic signed [ACC_W-1:0] q15(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + Q_ROUND;
        return t >>> COEF_W;
    endfunction

    // clamp to the signed sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
        lo = {{(ACC_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};
        if (v > hi) begin
            return hi[SAMPLE_W-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

### hw/rtl/srv_mul.sv
`timescale 1ns / 1ps
module srv_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srv_pkg::t_mul_req i_req,
    output srv_pkg::t_mul_rsp o_rsp
);
    import srv_pkg::*;

    logic                       r_busy;
    logic                       r_done;
    logic [MSTEP_W-1:0]         r_cnt;
    logic signed [SAMPLE_W-1:0] r_a;
    logic [MCOEF_W-1:0]         r_coef;
    logic signed [PROD_W-1:0]   r_prod;

    logic [DIGIT_W-1:0]             w_digit;
    logic signed [SAMPLE_W+DIGIT_W:0] w_pp;

    // one coefficient digit per cycle, most significant first
    assign w_digit = r_coef[MCOEF_W-1 -: DIGIT_W];
    assign w_pp    = r_a * $signed({1'b0, w_digit});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MSTEP_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand shift and partial product accumulation
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_req.a;
            r_coef <= i_req.coef;
            r_prod <= '0;
        end else if (r_busy) begin
            r_coef <= r_coef << DIGIT_W;
            r_prod <= (r_prod <<< DIGIT_W) + PROD_W'(w_pp);
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.prod = r_prod;
    end

endmodule

### hw/rtl/stereo_schroeder_reverb_core.sv
`timescale 1ns / 1ps
// Stereo reverb: six damped feedback combs averaged into two series allpasses,
// scaled by a wet gain and added to the dry sample with saturation.
// Input channel: i_in_valid with o_in_stall; one transfer carries the left and
// right send and dry samples. Output channel: o_out_valid with i_out_stall; one
// transfer carries the left and right mix.
// One stereo sample is worked on at a time, and a new item is taken only once
// the last one is finished. Both channels run in turn through the one shared
// multiplier, and each product holds the sequencer through its start, four
// 4-bit coefficient digits and done. Per channel the six combs are followed by
// the bit-serial comb average, the two allpasses and the wet gain.
// The input is taken again as soon as the result sits in the output register,
// so a result waiting on a stalled receiver does not hold up the next item;
// only a second result waits for the first to leave.
// Registers sit on an APB-style port, 32-bit words at byte addresses 0, 4, 8, 12:
// comb decay, damping, wet gain, allpass gain; write only while idle.
// Reset is synchronous: registers return to their defaults, filter positions
// and damping states clear, and per-filter fill flags make the delay lines
// read as zero until written, so there is no clearing pass.
module stereo_schroeder_reverb_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [srv_pkg::SAMPLE_W-1:0] i_send_left,
    input  logic signed [srv_pkg::SAMPLE_W-1:0] i_send_right,
    input  logic signed [srv_pkg::SAMPLE_W-1:0] i_dry_left,
    input  logic signed [srv_pkg::SAMPLE_W-1:0] i_dry_right,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [srv_pkg::SAMPLE_W-1:0] o_mix_left,
    output logic signed [srv_pkg::SAMPLE_W-1:0] o_mix_right,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import srv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CRD, S_CDAT, S_CLP1, S_CLP2, S_CDEC, S_DIV, S_DIVQ,
        S_ARD, S_ADAT, S_AP1, S_AP2, S_WET, S_DONE
    } t_state;

    // configuration
    logic [COEF_W-1:0] r_decay, r_damping, r_wet, r_apgain;

    // sequencer
    t_state                     r_state;
    logic                       r_ch;
    logic [CK_W-1:0]            r_k;
    t_mul_req                   r_req;
    t_mul_rsp                   w_rsp;
    logic signed [SAMPLE_W-1:0] r_send [2];
    logic signed [SAMPLE_W-1:0] r_dry [2];
    logic signed [SAMPLE_W-1:0] r_d;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_o;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [CSUM_W-1:0]   r_csum;
    logic                       r_neg;
    logic [DIV_W-1:0]           r_div;
    logic [CK_W-1:0]            r_rem;
    logic [DCNT_W-1:0]          r_dcnt;
    logic signed [SAMPLE_W-1:0] r_mix_l, r_mix_r;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r;

    // filter state
    logic signed [SAMPLE_W-1:0] r_lp [2][COMB_COUNT];
    logic [CPOS_W-1:0]          r_cpos [COMB_COUNT];
    logic                       r_cfull [COMB_COUNT];
    logic [APOS_W-1:0]          r_apos [ALLPASS_COUNT];
    logic                       r_afull [ALLPASS_COUNT];

    // delay line memories
    logic signed [SAMPLE_W-1:0] mem_cl [COMB_COUNT*COMB_DEPTH_MAX];
    logic signed [SAMPLE_W-1:0] mem_cr [COMB_COUNT*COMB_DEPTH_MAX];
    logic signed [SAMPLE_W-1:0] mem_al [ALLPASS_COUNT*ALLPASS_DEPTH_MAX];
    logic signed [SAMPLE_W-1:0] mem_ar [ALLPASS_COUNT*ALLPASS_DEPTH_MAX];
    logic signed [SAMPLE_W-1:0] r_crd_l, r_crd_r, r_ard_l, r_ard_r;

    logic [AK_W-1:0]            w_ak;
    logic [CADDR_W-1:0]         w_caddr;
    logic [AADDR_W-1:0]         w_aaddr;
    logic signed [SAMPLE_W-1:0] w_cd, w_ad;
    logic signed [SAMPLE_W-1:0] w_lpn, w_cwr, w_ao, w_awr, w_mix, w_q;
    logic signed [CSUM_W-1:0]   w_csum_n;
    logic [DIV_W-1:0]           w_mag;
    logic [CK_W:0]              w_dt;
    logic                       w_dge;
    logic                       w_cwe, w_awe, w_load, w_pos_ok;
    logic signed [ACC_W-1:0]    w_prod;

    srv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay   <= DECAY_RST;
            r_damping <= DAMPING_RST;
            r_wet     <= WET_RST;
            r_apgain  <= APGAIN_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_DECAY:   r_decay   <= pwdata[COEF_W-1:0];
                REG_DAMPING: r_damping <= pwdata[COEF_W-1:0];
                REG_WET:     r_wet     <= pwdata[COEF_W-1:0];
                REG_APGAIN:  r_apgain  <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DECAY:   prdata = 32'(r_decay);
            REG_DAMPING: prdata = 32'(r_damping);
            REG_WET:     prdata = 32'(r_wet);
            REG_APGAIN:  prdata = 32'(r_apgain);
            default:     prdata = '0;
        endcase
    end

    // addresses and datapath
    always_comb begin
        w_ak     = r_k[AK_W-1:0];
        w_caddr  = {r_k, r_cpos[r_k]};
        w_aaddr  = {w_ak, r_apos[w_ak]};
        w_prod   = ACC_W'(w_rsp.prod);
        w_cd     = r_cfull[r_k] ? (r_ch ? r_crd_r : r_crd_l) : '0;
        w_ad     = r_afull[w_ak] ? (r_ch ? r_ard_r : r_ard_l) : '0;
        w_lpn    = sat_s(q15(r_acc + w_prod));
        w_cwr    = sat_s(ACC_W'(r_send[r_ch]) + q15(w_prod));
        w_ao     = sat_s(ACC_W'(r_d) - q15(w_prod));
        w_awr    = sat_s(ACC_W'(r_x) + q15(w_prod));
        w_mix    = sat_s(ACC_W'(r_dry[r_ch]) + q15(w_prod));
        w_csum_n = r_csum + CSUM_W'(r_d);
        w_mag    = w_csum_n[CSUM_W-1] ? DIV_W'(-w_csum_n) : DIV_W'(w_csum_n);
        w_dt     = {r_rem, r_div[DIV_W-1]};
        w_dge    = (w_dt >= (CK_W+1)'(COMB_COUNT));
        w_q      = SAMPLE_W'(r_div);
        w_cwe    = (r_state == S_CDEC) && w_rsp.done;
        w_awe    = (r_state == S_AP2) && w_rsp.done;
        w_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    end

    // delay line memories, registered reads
    always_ff @(posedge i_clk) begin
        r_crd_l <= mem_cl[w_caddr];
        if (w_cwe && !r_ch) begin
            mem_cl[w_caddr] <= w_cwr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crd_r <= mem_cr[w_caddr];
        if (w_cwe && r_ch) begin
            mem_cr[w_caddr] <= w_cwr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ard_l <= mem_al[w_aaddr];
        if (w_awe && !r_ch) begin
            mem_al[w_aaddr] <= w_awr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ard_r <= mem_ar[w_aaddr];
        if (w_awe && r_ch) begin
            mem_ar[w_aaddr] <= w_awr;
        end
    end

    // sequencer: combs, average, allpasses and mix, left then right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= 1'b0;
            r_k         <= '0;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                for (int i = 0; i < COMB_COUNT; i++) begin
                    r_lp[c][i] <= '0;
                end
            end
            for (int i = 0; i < COMB_COUNT; i++) begin
                r_cpos[i]  <= '0;
                r_cfull[i] <= 1'b0;
            end
            for (int i = 0; i < ALLPASS_COUNT; i++) begin
                r_apos[i]  <= '0;
                r_afull[i] <= 1'b0;
            end
        end else begin
            r_req.start <= 1'b0;
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_l     <= r_mix_l;
                r_out_r     <= r_mix_r;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_send[0] <= i_send_left;
                        r_send[1] <= i_send_right;
                        r_dry[0]  <= i_dry_left;
                        r_dry[1]  <= i_dry_right;
                        r_ch      <= 1'b0;
                        r_k       <= '0;
                        r_csum    <= '0;
                        r_state   <= S_CRD;
                    end
                end
                S_CRD: r_state <= S_CDAT;
                S_CDAT: begin
                    r_d     <= w_cd;
                    r_req   <= '{start: 1'b1, a: w_cd, coef: Q_ONE - {1'b0, r_damping}};
                    r_state <= S_CLP1;
                end
                S_CLP1: begin
                    if (w_rsp.done) begin
                        r_acc   <= w_prod;
                        r_req   <= '{start: 1'b1, a: r_lp[r_ch][r_k], coef: {1'b0, r_damping}};
                        r_state <= S_CLP2;
                    end
                end
                S_CLP2: begin
                    if (w_rsp.done) begin
                        r_lp[r_ch][r_k] <= w_lpn;
                        r_req   <= '{start: 1'b1, a: w_lpn, coef: {1'b0, r_decay}};
                        r_state <= S_CDEC;
                    end
                end
                S_CDEC: begin
                    if (w_rsp.done) begin
                        r_csum <= w_csum_n;
                        if (r_k == CK_W'(COMB_COUNT - 1)) begin
                            r_neg   <= w_csum_n[CSUM_W-1];
                            r_div   <= w_mag;
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_CRD;
                        end
                    end
                end
                // restoring division by the comb count, one quotient bit a cycle
                S_DIV: begin
                    r_rem  <= w_dge ? CK_W'(w_dt - (CK_W+1)'(COMB_COUNT)) : CK_W'(w_dt);
                    r_div  <= {r_div[DIV_W-2:0], w_dge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCNT_W'(DIV_W - 1)) begin
                        r_state <= S_DIVQ;
                    end
                end
                S_DIVQ: begin
                    r_x     <= r_neg ? -w_q : w_q;
                    r_k     <= '0;
                    r_state <= S_ARD;
                end
                S_ARD: r_state <= S_ADAT;
                S_ADAT: begin
                    r_d     <= w_ad;
                    r_req   <= '{start: 1'b1, a: r_x, coef: {1'b0, r_apgain}};
                    r_state <= S_AP1;
                end
                S_AP1: begin
                    if (w_rsp.done) begin
                        r_o     <= w_ao;
                        r_req   <= '{start: 1'b1, a: w_ao, coef: {1'b0, r_apgain}};
                        r_state <= S_AP2;
                    end
                end
                S_AP2: begin
                    if (w_rsp.done) begin
                        r_x <= r_o;
                        if (w_ak == AK_W'(ALLPASS_COUNT - 1)) begin
                            r_req   <= '{start: 1'b1, a: r_o, coef: {1'b0, r_wet}};
                            r_state <= S_WET;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_ARD;
                        end
                    end
                end
                S_WET: begin
                    if (w_rsp.done) begin
                        if (!r_ch) begin
                            r_mix_l <= w_mix;
                            r_ch    <= 1'b1;
                            r_k     <= '0;
                            r_csum  <= '0;
                            r_state <= S_CRD;
                        end else begin
                            r_mix_r <= w_mix;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        // advance the shared filter positions
                        for (int i = 0; i < COMB_COUNT; i++) begin
                            if ((CPOS_W+1)'({1'b0, r_cpos[i]} + 1'b1) == COMB_LEN[i]) begin
                                r_cpos[i]  <= '0;
                                r_cfull[i] <= 1'b1;
                            end else begin
                                r_cpos[i] <= r_cpos[i] + 1'b1;
                            end
                        end
                        for (int i = 0; i < ALLPASS_COUNT; i++) begin
                            if ((APOS_W+1)'({1'b0, r_apos[i]} + 1'b1) == AP_LEN[i]) begin
                                r_apos[i]  <= '0;
                                r_afull[i] <= 1'b1;
                            end else begin
                                r_apos[i] <= r_apos[i] + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_mix_left  = r_out_l;
    assign o_mix_right = r_out_r;

    // every filter position stays inside its length
    always_comb begin
        w_pos_ok = 1'b1;
        for (int i = 0; i < COMB_COUNT; i++) begin
            if ({1'b0, r_cpos[i]} >= COMB_LEN[i]) begin
                w_pos_ok = 1'b0;
            end
        end
        for (int i = 0; i < ALLPASS_COUNT; i++) begin
            if ({1'b0, r_apos[i]} >= AP_LEN[i]) begin
                w_pos_ok = 1'b0;
            end
        end
    end

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again before the item started");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pos_ok)
        else $error("filter position beyond its length");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result presented outside the final step");

    a_no_dual_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cwe |-> (r_state != S_AP2) && !w_awe)
        else $error("comb and allpass lines written together");

endmodule

### tb/stereo_schroeder_reverb_core_test.sv
`timescale 1ns / 1ps
module stereo_schroeder_reverb_core_test;
    import srv_pkg::*;

    localparam int NUM_RANDOM  = 600;
    localparam int CYCLE_LIMIT = 2000000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample send_l;
        t_sample send_r;
        t_sample dry_l;
        t_sample dry_r;
    } t_frame;

    typedef struct packed {
        t_sample mix_l;
        t_sample mix_r;
    } t_mix;

    // directed row: stimulus plus an optional literal expectation
    typedef struct packed {
        t_frame frame;
        logic   has_lit;
        t_mix   lit;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_sample     send_l = '0, send_r = '0, dry_l = '0, dry_r = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_sample     mix_l, mix_r;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    stereo_schroeder_reverb_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_send_left(send_l), .i_send_right(send_r),
        .i_dry_left(dry_l), .i_dry_right(dry_r),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_mix_left(mix_l), .o_mix_right(mix_r),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // predictor state
    int unsigned       gain_decay, gain_damp, gain_wet, gain_ap;
    longint            comb_mem_l [COMB_COUNT*COMB_DEPTH_MAX];
    longint            comb_mem_r [COMB_COUNT*COMB_DEPTH_MAX];
    longint            damp_l [COMB_COUNT];
    longint            damp_r [COMB_COUNT];
    int unsigned       comb_pos [COMB_COUNT];
    longint            ap_mem_l [ALLPASS_COUNT*ALLPASS_DEPTH_MAX];
    longint            ap_mem_r [ALLPASS_COUNT*ALLPASS_DEPTH_MAX];
    int unsigned       ap_pos [ALLPASS_COUNT];
    int unsigned       comb_length [COMB_COUNT] = '{1492, 1867, 2068, 2212, 2510, 2942};
    int unsigned       ap_length [ALLPASS_COUNT] = '{240, 81};

    t_mix   pending_mix [$];
    t_mix   lit_mix [$];
    logic   lit_flag [$];
    int     errors = 0;
    int     cycles = 0;
    int     mixes_seen = 0;
    int     send_idle = 0, recv_idle = 0;

    function automatic longint clamp24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint round15(longint v);
        v = v + 16384;
        return v >>> 15;
    endfunction

    task automatic clear_filters();
        foreach (comb_mem_l[i]) begin comb_mem_l[i] = 0; comb_mem_r[i] = 0; end
        foreach (ap_mem_l[i]) begin ap_mem_l[i] = 0; ap_mem_r[i] = 0; end
        foreach (damp_l[i]) begin damp_l[i] = 0; damp_r[i] = 0; comb_pos[i] = 0; end
        foreach (ap_pos[i]) ap_pos[i] = 0;
        gain_decay = DECAY_RST; gain_damp = DAMPING_RST;
        gain_wet = WET_RST; gain_ap = APGAIN_RST;
    endtask

    function automatic longint comb_tap(ref longint mem [COMB_COUNT*COMB_DEPTH_MAX],
                                        ref longint lp, input int unsigned addr,
                                        input longint x);
        longint d;
        d = mem[addr];
        lp = clamp24(round15(d * longint'(32768 - gain_damp) + lp * longint'(gain_damp)));
        mem[addr] = clamp24(x + round15(lp * longint'(gain_decay)));
        return d;
    endfunction

    function automatic longint ap_tap(ref longint mem [ALLPASS_COUNT*ALLPASS_DEPTH_MAX],
                                      input int unsigned addr, input longint x);
        longint d, o;
        d = mem[addr];
        o = clamp24(d - round15(x * longint'(gain_ap)));
        mem[addr] = clamp24(x + round15(o * longint'(gain_ap)));
        return o;
    endfunction

    // reverb predictor for one stereo frame
    function automatic t_mix reverb_mix(t_frame f);
        longint      acc_l, acc_r;
        int unsigned p, base;
        t_mix        m;
        acc_l = 0; acc_r = 0;
        for (int k = 0; k < COMB_COUNT; k++) begin
            p = comb_pos[k];
            if (p >= comb_length[k]) p = 0;
            base = k * COMB_DEPTH_MAX;
            acc_l += comb_tap(comb_mem_l, damp_l[k], base + p, longint'(f.send_l));
            acc_r += comb_tap(comb_mem_r, damp_r[k], base + p, longint'(f.send_r));
            p++;
            comb_pos[k] = (p >= comb_length[k]) ? 0 : p;
        end
        acc_l = acc_l / COMB_COUNT;
        acc_r = acc_r / COMB_COUNT;
        for (int k = 0; k < ALLPASS_COUNT; k++) begin
            p = ap_pos[k];
            if (p >= ap_length[k]) p = 0;
            base = k * ALLPASS_DEPTH_MAX;
            acc_l = ap_tap(ap_mem_l, base + p, acc_l);
            acc_r = ap_tap(ap_mem_r, base + p, acc_r);
            p++;
            ap_pos[k] = (p >= ap_length[k]) ? 0 : p;
        end
        m.mix_l = t_sample'(clamp24(longint'(f.dry_l) + round15(acc_l * longint'(gain_wet))));
        m.mix_r = t_sample'(clamp24(longint'(f.dry_r) + round15(acc_r * longint'(gain_wet))));
        return m;
    endfunction

    // cycle counter and timeout
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk) begin
        out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end

    // result check on every output transfer
    always @(posedge clk) begin
        t_mix   want;
        logic   use_lit;
        t_mix   lit;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_mix.size() == 0) begin
                $display("%0t unexpected mix %0d %0d", $time, mix_l, mix_r);
                errors++;
            end else begin
                want = pending_mix.pop_front();
                use_lit = lit_flag.pop_front();
                lit = lit_mix.pop_front();
                if (use_lit) want = lit;
                if (mix_l !== want.mix_l) begin
                    $display("%0t mix_left expected %0d actual %0d", $time, want.mix_l, mix_l);
                    errors++;
                end
                if (mix_r !== want.mix_r) begin
                    $display("%0t mix_right expected %0d actual %0d", $time, want.mix_r, mix_r);
                    errors++;
                end
            end
            mixes_seen++;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_DECAY:   gain_decay = val[COEF_W-1:0];
            REG_DAMPING: gain_damp = val[COEF_W-1:0];
            REG_WET:     gain_wet = val[COEF_W-1:0];
            default:     gain_ap = val[COEF_W-1:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_mix.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // one input transfer, called at a falling edge, returns at a later one
    task automatic send_frame(t_frame f, logic has_lit, t_mix lit);
        while ((send_idle > 0) && ($urandom_range(99) < send_idle)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        send_l <= f.send_l; send_r <= f.send_r; dry_l <= f.dry_l; dry_r <= f.dry_r;
        do @(posedge clk); while (in_stall);
        pending_mix.push_back(reverb_mix(f));
        lit_flag.push_back(has_lit);
        lit_mix.push_back(lit);
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic t_sample rnd_sample();
        case ($urandom_range(5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return t_sample'($urandom_range(4095)) - 2048;
            default: return t_sample'($urandom);
        endcase
    endfunction

    t_row directed [14];

    initial begin
        t_frame f;
        t_mix   m;
        clear_filters();
        // silence, dry extremes with empty lines, then driven sends
        directed[0]  = '{'{0, 0, 0, 0}, 1'b1, '{0, 0}};
        directed[1]  = '{'{0, 0, 24'sh7fffff, 24'sh800000}, 1'b1, '{24'sh7fffff, 24'sh800000}};
        directed[2]  = '{'{0, 0, 24'sh800000, 24'sh7fffff}, 1'b1, '{24'sh800000, 24'sh7fffff}};
        directed[3]  = '{'{0, 0, 24'sh123456, -24'sh0abcde}, 1'b1, '{24'sh123456, -24'sh0abcde}};
        directed[4]  = '{'{24'sh7fffff, 24'sh800000, 0, 0}, 1'b0, '0};
        directed[5]  = '{'{24'sh800000, 24'sh7fffff, 0, 0}, 1'b0, '0};
        directed[6]  = '{'{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff}, 1'b0, '0};
        directed[7]  = '{'{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000}, 1'b0, '0};
        directed[8]  = '{'{1, -1, 1, -1}, 1'b0, '0};
        directed[9]  = '{'{24'sh555555, 24'shaaaaaa, 24'shaaaaaa, 24'sh555555}, 1'b0, '0};
        directed[10] = '{'{24'sh400000, -24'sh400000, 0, 0}, 1'b0, '0};
        directed[11] = '{'{0, 0, 24'sh7ffff0, 24'sh800010}, 1'b0, '0};
        directed[12] = '{'{-24'sh000001, 24'sh000001, 0, 0}, 1'b0, '0};
        directed[13] = '{'{24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000}, 1'b0, '0};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset coefficients
        foreach (directed[i]) send_frame(directed[i].frame, directed[i].has_lit, directed[i].lit);
        wait_drained();

        // coefficient extremes: a short random burst at the first set, the second set left for the random part
        reg_write(REG_DECAY, 32'h7fff);
        reg_write(REG_DAMPING, 32'h0);
        reg_write(REG_WET, 32'h7fff);
        reg_write(REG_APGAIN, 32'h7fff);
        for (int i = 0; i < 8; i++) begin
            f = '{rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample()};
            send_frame(f, 1'b0, '0);
        end
        wait_drained();
        reg_write(REG_DECAY, 32'h0);
        reg_write(REG_DAMPING, 32'h7fff);
        reg_write(REG_WET, 32'h0);
        reg_write(REG_APGAIN, 32'hffff_0000);

        // random part in idling phases, new settings per phase
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 87; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 87; end
                3: begin send_idle = 33; recv_idle = 33; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int i = 0; i < NUM_RANDOM / 5; i++) begin
                f = '{rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample()};
                send_frame(f, 1'b0, '0);
            end
            // pause until every result is in, then retune
            wait_drained();
            reg_write(REG_DECAY, $urandom);
            reg_write(REG_DAMPING, $urandom);
            reg_write(REG_WET, $urandom);
            reg_write(REG_APGAIN, $urandom);
        end
        send_idle = 0; recv_idle = 0;
        wait_drained();

        $display("covered %0d stereo mixes over reset, extreme and random coefficients,",
                 mixes_seen);
        $display("with sender gaps and receiver stalls in separate and joint phases");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
